/* rtl/sca_pkg.sv */
// package: types, opcodes, sbox tables and gf helpers for the segment alu
`timescale 1ns / 1ps
`default_nettype none
package sca_pkg;

  typedef enum logic [3:0] {
    OP_EOR3    = 4'd0,
    OP_BCAX    = 4'd1,
    OP_AESMC   = 4'd2,
    OP_AESIMC  = 4'd3,
    OP_AESE    = 4'd4,
    OP_AESD    = 4'd5,
    OP_AESEMC  = 4'd6,
    OP_AESDIMC = 4'd7,
    OP_SM4E    = 4'd8,
    OP_SM4EKEY = 4'd9,
    OP_RAX1    = 4'd10,
    OP_XAR     = 4'd11
  } op_e;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [63:0] first_low;
    logic [63:0] first_high;
    logic [63:0] second_low;
    logic [63:0] second_high;
    logic [63:0] third_low;
    logic [63:0] third_high;
    logic [1:0]  element_size;
    logic [6:0]  rotate_amount;
  } req_t;

  typedef struct packed {
    logic [63:0] result_low;
    logic [63:0] result_high;
  } rsp_t;

  localparam logic [7:0] AES_POLY = 8'h1b;

  function automatic logic [7:0] xt(input logic [7:0] v);
    xt = {v[6:0], 1'b0} ^ (v[7] ? AES_POLY : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] x;
    acc = 8'h00;
    x   = a;
    for (int k = 0; k < 4; k++) begin
      if (b[k]) acc = acc ^ x;
      x = xt(x);
    end
    gmul = acc;
  endfunction

  function automatic logic [127:0] mix_cols(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    logic [7:0] c0, c1, c2, c3, m0, m1, m2, m3;
    m0 = inv ? 8'h0e : 8'h02;
    m1 = inv ? 8'h0b : 8'h03;
    m2 = inv ? 8'h0d : 8'h01;
    m3 = inv ? 8'h09 : 8'h01;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      c0 = s[c*32 +: 8];
      c1 = s[c*32+8 +: 8];
      c2 = s[c*32+16 +: 8];
      c3 = s[c*32+24 +: 8];
      o[c*32 +: 8]    = gmul(c0, m0) ^ gmul(c1, m1) ^ gmul(c2, m2) ^ gmul(c3, m3);
      o[c*32+8 +: 8]  = gmul(c0, m3) ^ gmul(c1, m0) ^ gmul(c2, m1) ^ gmul(c3, m2);
      o[c*32+16 +: 8] = gmul(c0, m2) ^ gmul(c1, m3) ^ gmul(c2, m0) ^ gmul(c3, m1);
      o[c*32+24 +: 8] = gmul(c0, m1) ^ gmul(c1, m2) ^ gmul(c2, m3) ^ gmul(c3, m0);
    end
    mix_cols = o;
  endfunction

  localparam logic [7:0] AES_FWD [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] AES_INV [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  localparam logic [7:0] SM4_BOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  function automatic logic [31:0] sm4_round(input logic [127:0] x, input logic [31:0] rk,
                                            input logic keyexp);
    logic [31:0] t, u, l;
    t = x[63:32] ^ x[95:64] ^ x[127:96] ^ rk;
    for (int i = 0; i < 4; i++) u[i*8 +: 8] = SM4_BOX[t[i*8 +: 8]];
    if (keyexp) l = u ^ {u[18:0], u[31:19]} ^ {u[8:0], u[31:9]};
    else l = u ^ {u[29:0], u[31:30]} ^ {u[21:0], u[31:22]} ^ {u[13:0], u[31:14]}
             ^ {u[7:0], u[31:8]};
    sm4_round = l ^ x[31:0];
  endfunction

endpackage : sca_pkg
`default_nettype wire

/* rtl/sca_front.sv */
// stage 1: key add, byte substitution and shift rows, simple xor and rotate ops, first sm4 round
`timescale 1ns / 1ps
`default_nettype none
module sca_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          vld_i,
  input  wire sca_pkg::req_t req_i,
  output logic               vld_o,
  output logic [3:0]         op_o,
  output logic [127:0]       st_o,
  output logic [127:0]       key_o
);
  import sca_pkg::*;

  logic         vld_q;
  logic [3:0]   op_q, op_d;
  logic [127:0] st_q, st_d, key_q;
  logic [127:0] a, b, c, s, sub, sr, xv;
  logic [63:0]  xl, xh;
  logic         inv;
  logic [6:0]   r;

  function automatic logic [63:0] xar_lane(input logic [63:0] v, input logic [1:0] esz,
                                           input logic [6:0] rot);
    logic [63:0] o;
    logic [5:0]  rr;
    o = '0;
    case (esz)
      2'd0: begin
        rr = {3'b000, rot[2:0]};
        for (int e = 0; e < 8; e++) o[e*8 +: 8] = 8'({v[e*8 +: 8], v[e*8 +: 8]} >> rr);
      end
      2'd1: begin
        rr = {2'b00, rot[3:0]};
        for (int e = 0; e < 4; e++) o[e*16 +: 16] = 16'({v[e*16 +: 16], v[e*16 +: 16]} >> rr);
      end
      2'd2: begin
        rr = {1'b0, rot[4:0]};
        for (int e = 0; e < 2; e++) o[e*32 +: 32] = 32'({v[e*32 +: 32], v[e*32 +: 32]} >> rr);
      end
      default: begin
        rr = rot[5:0];
        o = 64'({v, v} >> rr);
      end
    endcase
    xar_lane = o;
  endfunction

  assign a   = {req_i.first_high, req_i.first_low};
  assign b   = {req_i.second_high, req_i.second_low};
  assign c   = {req_i.third_high, req_i.third_low};
  assign s   = a ^ b;
  assign inv = (req_i.opcode == OP_AESD) || (req_i.opcode == OP_AESDIMC);
  assign r   = req_i.rotate_amount;
  assign xl  = xar_lane(s[63:0], req_i.element_size, r);
  assign xh  = xar_lane(s[127:64], req_i.element_size, r);
  assign xv  = {xh, xl};

  always_comb begin
    for (int i = 0; i < 16; i++) sub[i*8 +: 8] = inv ? AES_INV[s[i*8 +: 8]] : AES_FWD[s[i*8 +: 8]];
    for (int rw = 0; rw < 4; rw++) begin
      for (int cl = 0; cl < 4; cl++) begin
        sr[(rw + cl*4)*8 +: 8] = inv ? sub[(rw + ((cl + 4 - rw) % 4)*4)*8 +: 8]
                                     : sub[(rw + ((cl + rw) % 4)*4)*8 +: 8];
      end
    end
  end

  always_comb begin
    op_d = req_i.opcode;
    case (req_i.opcode)
      OP_EOR3: st_d = a ^ b ^ c;
      OP_BCAX: st_d = a ^ (b & ~c);
      OP_AESE, OP_AESD, OP_AESEMC, OP_AESDIMC: st_d = sr;
      OP_SM4E, OP_SM4EKEY:
        st_d = {sm4_round(a, b[31:0], req_i.opcode == OP_SM4EKEY), a[127:32]};
      OP_RAX1: st_d = a ^ {b[126:64], b[127], b[62:0], b[63]};
      OP_XAR:  st_d = xv;
      default: st_d = a;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_i) begin
      op_q  <= op_d;
      st_q  <= st_d;
      key_q <= b;
    end
  end

  assign vld_o = vld_q;
  assign op_o  = op_q;
  assign st_o  = st_q;
  assign key_o = key_q;
endmodule : sca_front
`default_nettype wire

/* rtl/sca_mid.sv */
// stage 2: sm4 rounds two and three
`timescale 1ns / 1ps
`default_nettype none
module sca_mid (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    vld_i,
  input  wire [3:0]    op_i,
  input  wire [127:0]  st_i,
  input  wire [127:0]  key_i,
  output logic         vld_o,
  output logic [3:0]   op_o,
  output logic [127:0] st_o,
  output logic [31:0]  rk_o
);
  import sca_pkg::*;

  logic         vld_q;
  logic [3:0]   op_q;
  logic [127:0] st_q, st_d, r1;
  logic [31:0]  rk_q;
  logic         ke, sm;

  assign ke = (op_i == OP_SM4EKEY);
  assign sm = (op_i == OP_SM4E) || ke;
  assign r1 = {sm4_round(st_i, key_i[63:32], ke), st_i[127:32]};
  assign st_d = sm ? {sm4_round(r1, key_i[95:64], ke), r1[127:32]} : st_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_i) begin
      op_q <= op_i;
      st_q <= st_d;
      rk_q <= key_i[127:96];
    end
  end

  assign vld_o = vld_q;
  assign op_o  = op_q;
  assign st_o  = st_q;
  assign rk_o  = rk_q;
endmodule : sca_mid
`default_nettype wire

/* rtl/sca_back.sv */
// stage 3: (inverse) mix columns and the last sm4 round
`timescale 1ns / 1ps
`default_nettype none
module sca_back (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    vld_i,
  input  wire [3:0]    op_i,
  input  wire [127:0]  st_i,
  input  wire [31:0]   rk_i,
  output logic         vld_o,
  output sca_pkg::rsp_t rsp_o
);
  import sca_pkg::*;

  logic         vld_q;
  logic [127:0] res_q, res_d;

  always_comb begin
    case (op_i)
      OP_AESMC, OP_AESEMC:   res_d = mix_cols(st_i, 1'b0);
      OP_AESIMC, OP_AESDIMC: res_d = mix_cols(st_i, 1'b1);
      OP_SM4E, OP_SM4EKEY:
        res_d = {sm4_round(st_i, rk_i, op_i == OP_SM4EKEY), st_i[127:32]};
      default: res_d = st_i;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_i) begin
      res_q <= res_d;
    end
  end

  assign vld_o = vld_q;
  assign rsp_o = '{result_low: res_q[63:0], result_high: res_q[127:64]};

`ifndef NO_ASSERTIONS
  a_vld_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_i |=> vld_q) else $error("result strobe lost");
  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_i |=> !vld_q) else $error("spurious result strobe");
  a_pass_default : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_i && (op_i == OP_EOR3 || op_i == OP_XAR)) |=> res_q == $past(st_i))
    else $error("pass-through op altered");
`endif
endmodule : sca_back
`default_nettype wire

/* rtl/sve_crypto_segment_alu_top.sv */
// top level of the sve2 crypto segment alu
// channel | dir | handshake         | payload
// request | in  | start_i / busy_o  | req_i  (sca_pkg::req_t)
// result  | out | done_o strobe     | rsp_o  (sca_pkg::rsp_t)
// three register stages, one transaction per cycle
// sm4 four-round work is split over the stages, one or two rounds each
// busy_o is never asserted; the receiver cannot stall and results never wait
// reset clears the stage valid bits only
`timescale 1ns / 1ps
`default_nettype none
module sve_crypto_segment_alu_top (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  output logic               busy_o,
  input  wire sca_pkg::req_t req_i,
  output logic               done_o,
  output sca_pkg::rsp_t      rsp_o
);
  import sca_pkg::*;

  logic         v1, v2;
  logic [3:0]   op1, op2;
  logic [127:0] st1, key1, st2;
  logic [31:0]  rk2;

  assign busy_o = 1'b0;

  sca_front u_front (
    .clk_i, .rst_ni, .vld_i(start_i), .req_i,
    .vld_o(v1), .op_o(op1), .st_o(st1), .key_o(key1)
  );

  sca_mid u_mid (
    .clk_i, .rst_ni, .vld_i(v1), .op_i(op1), .st_i(st1), .key_i(key1),
    .vld_o(v2), .op_o(op2), .st_o(st2), .rk_o(rk2)
  );

  sca_back u_back (
    .clk_i, .rst_ni, .vld_i(v2), .op_i(op2), .st_i(st2), .rk_i(rk2),
    .vld_o(done_o), .rsp_o
  );
endmodule : sve_crypto_segment_alu_top
`default_nettype wire
